>>> src/vbt_pkg.sv
// ----------------------------------------------------------------------------
// vbt_pkg
// Shared types and constants of the blob tracker: the stored entry, the
// controller to datapath command and status groups, register indexes.
// ----------------------------------------------------------------------------
package vbt_pkg;

  localparam int CoordW = 10;
  localparam int SigW   = 3;
  localparam int LifeW  = 3;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LIFE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POS_THR  = 2'd1;

  localparam logic [LifeW-1:0]  MAX_LIFE_RST = 3'd6;
  localparam logic [CoordW-1:0] POS_THR_RST  = 10'd10;

  // divide by ten as multiply by 6554 then shift by 16, exact below 10240
  localparam logic [12:0] DIV10_MUL = 13'd6554;

  typedef struct packed {
    logic [SigW-1:0]   sig;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [LifeW-1:0]  life;
  } ent_t;

  typedef enum logic [2:0] {
    WS_IN    = 3'd0,
    WS_A     = 3'd1,
    WS_B     = 3'd2,
    WS_Q     = 3'd3,
    WS_BLEND = 3'd4,
    WS_NEW   = 3'd5,
    WS_DEC   = 3'd6
  } wsel_t;

  typedef struct packed {
    logic  sel_trk;
    logic  load_a;
    logic  load_b;
    logic  load_o;
    logic  clr_flags;
    logic  set_flag;
    logic  emit;
    logic  emit_valid;
    logic  emit_last;
    wsel_t wsel;
  } cmd_t;

  typedef struct packed {
    logic             is_match;
    logic             q_gt;
    logic [LifeW-1:0] q_life;
    logic [LifeW-1:0] max_life;
  } sts_t;

  // (new + 9 * old) / 10, truncated
  function automatic logic [CoordW-1:0] blend_size(input logic [CoordW-1:0] od,
                                                   input logic [CoordW-1:0] nw);
    logic [13:0] v;
    logic [26:0] p;
    v = 14'(nw) + (14'(od) << 3) + 14'(od);
    p = 27'(v) * 27'(DIV10_MUL);
    return p[25:16];
  endfunction

endpackage

>>> src/vbt_ram.sv
// ----------------------------------------------------------------------------
// vbt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vbt_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/vbt_dp.sv
// ----------------------------------------------------------------------------
// vbt_dp
// Datapath: object and track stores, work registers, match compare,
// blending arithmetic, match flags, configuration and result registers.
// ----------------------------------------------------------------------------
module vbt_dp #(
  parameter int MAX_OBJECTS = 8,
  parameter int TRACK_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vbt_pkg::cmd_t                     cmd,
  input  logic                              obj_we,
  input  logic [(MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1)-1:0] obj_waddr,
  input  logic [(MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1)-1:0] obj_raddr,
  input  logic                              trk_we,
  input  logic [$clog2(TRACK_SLOTS)-1:0]    trk_waddr,
  input  logic [$clog2(TRACK_SLOTS)-1:0]    trk_raddr,
  output vbt_pkg::sts_t                     sts,
  input  logic [vbt_pkg::SigW-1:0]          in_signature,
  input  logic [vbt_pkg::CoordW-1:0]        in_pos_x,
  input  logic [vbt_pkg::CoordW-1:0]        in_pos_y,
  input  logic [vbt_pkg::CoordW-1:0]        in_blob_width,
  input  logic [vbt_pkg::CoordW-1:0]        in_blob_height,
  input  logic [vbt_pkg::CoordW-1:0]        in_centre_x,
  input  logic [vbt_pkg::CoordW-1:0]        in_centre_y,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vbt_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [vbt_pkg::CfgDataW-1:0]      cfg_data,
  output logic                              out_valid,
  output logic                              out_track_valid,
  output logic [vbt_pkg::SigW-1:0]          out_signature,
  output logic [vbt_pkg::CoordW-1:0]        out_x,
  output logic [vbt_pkg::CoordW-1:0]        out_y,
  output logic [vbt_pkg::CoordW-1:0]        out_width,
  output logic [vbt_pkg::CoordW-1:0]        out_height,
  output logic [vbt_pkg::CoordW-1:0]        out_size,
  output logic [vbt_pkg::CoordW-1:0]        out_centre_x,
  output logic [vbt_pkg::CoordW-1:0]        out_centre_y,
  output logic                              out_last_slot
);

  localparam int EntW = $bits(vbt_pkg::ent_t);

  vbt_pkg::ent_t obj_q, trk_q, q, wdata;
  vbt_pkg::ent_t a_r, b_r, o_r, in_ent, blend_ent, new_ent, dec_ent;
  logic [vbt_pkg::LifeW-1:0]  max_life_r;
  logic [vbt_pkg::CoordW-1:0] pos_thr_r;
  logic [TRACK_SLOTS-1:0]     flags_r;
  logic                       flag_q_r;
  logic [vbt_pkg::CoordW-1:0] dx, dy;
  logic [vbt_pkg::LifeW:0]    life_inc;
  logic                       live;
  logic [vbt_pkg::CoordW:0]   size_sum;

  logic                       out_valid_r, out_track_valid_r, out_last_slot_r;
  logic [vbt_pkg::SigW-1:0]   out_sig_r;
  logic [vbt_pkg::CoordW-1:0] out_x_r, out_y_r, out_w_r, out_h_r, out_size_r;
  logic [vbt_pkg::CoordW-1:0] out_cx_r, out_cy_r;

  vbt_ram #(.WIDTH(EntW), .DEPTH(MAX_OBJECTS)) u_obj_ram (
    .clk  (clk),
    .we   (obj_we),
    .waddr(obj_waddr),
    .wdata(wdata),
    .raddr(obj_raddr),
    .rdata(obj_q)
  );

  vbt_ram #(.WIDTH(EntW), .DEPTH(TRACK_SLOTS)) u_trk_ram (
    .clk  (clk),
    .we   (trk_we),
    .waddr(trk_waddr),
    .wdata(wdata),
    .raddr(trk_raddr),
    .rdata(trk_q)
  );

  assign q = cmd.sel_trk ? trk_q : obj_q;

  always_comb begin
    in_ent      = '0;
    in_ent.sig  = in_signature;
    in_ent.x    = in_pos_x;
    in_ent.y    = in_pos_y;
    in_ent.w    = in_blob_width;
    in_ent.h    = in_blob_height;
    in_ent.cx   = in_centre_x;
    in_ent.cy   = in_centre_y;

    life_inc    = {1'b0, trk_q.life} + 1'b1;
    blend_ent   = trk_q;
    blend_ent.x  = vbt_pkg::CoordW'(({1'b0, trk_q.x} + {1'b0, o_r.x}) >> 1);
    blend_ent.y  = vbt_pkg::CoordW'(({1'b0, trk_q.y} + {1'b0, o_r.y}) >> 1);
    blend_ent.cx = vbt_pkg::CoordW'(({1'b0, trk_q.cx} + {1'b0, o_r.cx}) >> 1);
    blend_ent.cy = vbt_pkg::CoordW'(({1'b0, trk_q.cy} + {1'b0, o_r.cy}) >> 1);
    blend_ent.w  = vbt_pkg::blend_size(trk_q.w, o_r.w);
    blend_ent.h  = vbt_pkg::blend_size(trk_q.h, o_r.h);
    blend_ent.life = (life_inc > {1'b0, max_life_r}) ? max_life_r
                                                      : vbt_pkg::LifeW'(life_inc);

    new_ent      = o_r;
    new_ent.life = (max_life_r == '0) ? '0 : vbt_pkg::LifeW'(1);

    dec_ent      = trk_q;
    if (!flag_q_r && trk_q.life != '0) begin
      dec_ent.life = trk_q.life - 1'b1;
    end

    unique case (cmd.wsel)
      vbt_pkg::WS_IN:    wdata = in_ent;
      vbt_pkg::WS_A:     wdata = a_r;
      vbt_pkg::WS_B:     wdata = b_r;
      vbt_pkg::WS_Q:     wdata = q;
      vbt_pkg::WS_BLEND: wdata = blend_ent;
      vbt_pkg::WS_NEW:   wdata = new_ent;
      vbt_pkg::WS_DEC:   wdata = dec_ent;
      default:           wdata = in_ent;
    endcase
  end

  // centre distance per axis, strict
  always_comb begin
    dx = (trk_q.cx > o_r.cx) ? trk_q.cx - o_r.cx : o_r.cx - trk_q.cx;
    dy = (trk_q.cy > o_r.cy) ? trk_q.cy - o_r.cy : o_r.cy - trk_q.cy;
    sts.is_match = !flag_q_r && (trk_q.sig == o_r.sig) &&
                   (dx < pos_thr_r) && (dy < pos_thr_r);
    sts.q_gt     = q.y > b_r.y;
    sts.q_life   = q.life;
    sts.max_life = max_life_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_r <= q;
    end
    if (cmd.load_b) begin
      b_r <= q;
    end
    if (cmd.load_o) begin
      o_r <= obj_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '0;
      flag_q_r <= 1'b0;
    end else begin
      flag_q_r <= flags_r[trk_raddr];
      if (cmd.clr_flags) begin
        flags_r <= '0;
      end else if (cmd.set_flag) begin
        flags_r[trk_waddr] <= 1'b1;
      end
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_life_r <= vbt_pkg::MAX_LIFE_RST;
      pos_thr_r  <= vbt_pkg::POS_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vbt_pkg::CFG_MAX_LIFE: max_life_r <= cfg_data[vbt_pkg::LifeW-1:0];
        vbt_pkg::CFG_POS_THR:  pos_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // export: slot is stable when life nonzero and life + 1 >= max_life
  always_comb begin
    live     = cmd.emit_valid && (trk_q.life != '0) &&
               (({1'b0, trk_q.life} + 1'b1) >= {1'b0, max_life_r});
    size_sum = {1'b0, trk_q.w} + {1'b0, trk_q.h};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_track_valid_r <= live;
      out_last_slot_r   <= cmd.emit_last;
      out_sig_r  <= live ? trk_q.sig : '0;
      out_x_r    <= live ? trk_q.x : '0;
      out_y_r    <= live ? trk_q.y : '0;
      out_w_r    <= live ? trk_q.w : '0;
      out_h_r    <= live ? trk_q.h : '0;
      out_size_r <= live ? size_sum[vbt_pkg::CoordW:1] : '0;
      out_cx_r   <= live ? trk_q.cx : '0;
      out_cy_r   <= live ? trk_q.cy : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_track_valid = out_track_valid_r;
  assign out_signature   = out_sig_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_width       = out_w_r;
  assign out_height      = out_h_r;
  assign out_size        = out_size_r;
  assign out_centre_x    = out_cx_r;
  assign out_centre_y    = out_cy_r;
  assign out_last_slot   = out_last_slot_r;

endmodule

>>> src/vbt_ctrl.sv
// ----------------------------------------------------------------------------
// vbt_ctrl
// Controller: frame capture, object sort, track matching, life update,
// grouping by life with per-group sort, and slot export.
// ----------------------------------------------------------------------------
module vbt_ctrl #(
  parameter int MAX_OBJECTS = 8,
  parameter int TRACK_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_object_present,
  input  logic [vbt_pkg::SigW-1:0]          in_signature,
  input  logic                              in_frame_end,
  input  vbt_pkg::sts_t                     sts,
  output vbt_pkg::cmd_t                     cmd,
  output logic                              obj_we,
  output logic [(MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1)-1:0] obj_waddr,
  output logic [(MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1)-1:0] obj_raddr,
  output logic                              trk_we,
  output logic [$clog2(TRACK_SLOTS)-1:0]    trk_waddr,
  output logic [$clog2(TRACK_SLOTS)-1:0]    trk_raddr
);

  localparam int Depth = (TRACK_SLOTS > MAX_OBJECTS) ? TRACK_SLOTS : MAX_OBJECTS;
  localparam int SW    = $clog2(Depth + 1);
  localparam int AW    = $clog2(TRACK_SLOTS);
  localparam int OAW   = MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1;
  localparam int OCW   = $clog2(MAX_OBJECTS + 1);

  typedef enum logic [21:0] {
    ST_IDLE    = 22'b0000000000000000000001,
    ST_SS_INIT = 22'b0000000000000000000010,
    ST_SS_WS   = 22'b0000000000000000000100,
    ST_SS_CMP  = 22'b0000000000000000001000,
    ST_SS_SWP  = 22'b0000000000000000010000,
    ST_SS_SWP2 = 22'b0000000000000000100000,
    ST_M_INIT  = 22'b0000000000000001000000,
    ST_M_OBJ   = 22'b0000000000000010000000,
    ST_M_OBJW  = 22'b0000000000000100000000,
    ST_M_SCAN  = 22'b0000000000001000000000,
    ST_M_NEW   = 22'b0000000000010000000000,
    ST_D_RD    = 22'b0000000000100000000000,
    ST_D_WR    = 22'b0000000001000000000000,
    ST_G_L     = 22'b0000000010000000000000,
    ST_P_I     = 22'b0000000100000000000000,
    ST_P_IW    = 22'b0000001000000000000000,
    ST_P_J     = 22'b0000010000000000000000,
    ST_P_JW    = 22'b0000100000000000000000,
    ST_P_SW2   = 22'b0001000000000000000000,
    ST_X_RD    = 22'b0010000000000000000000,
    ST_X_EM    = 22'b0100000000000000000000,
    ST_DONE    = 22'b1000000000000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] i_r, i_nxt, j_r, j_nxt, g_r, g_nxt, hi_r, hi_nxt, jp_r, jp_nxt;
  logic [SW-1:0] first_r, first_nxt, end_r, end_nxt, n_r, n_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt, k_r, k_nxt;
  logic [OCW-1:0] obj_cnt_r, obj_cnt_nxt;
  logic [vbt_pkg::LifeW-1:0] lvl_r, lvl_nxt;
  logic sel_r, sel_nxt;
  logic [SW-1:0] rd_idx, wr_idx;
  logic we, take;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    g_nxt       = g_r;
    hi_nxt      = hi_r;
    jp_nxt      = jp_r;
    first_nxt   = first_r;
    end_nxt     = end_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    obj_cnt_nxt = obj_cnt_r;
    lvl_nxt     = lvl_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.sel_trk = sel_r;
    cmd.wsel    = vbt_pkg::WS_Q;
    rd_idx      = '0;
    wr_idx      = '0;
    we          = 1'b0;
    obj_we      = 1'b0;
    take        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          take = in_object_present && (in_signature != '0) &&
                 (obj_cnt_r < OCW'(MAX_OBJECTS));
          if (take) begin
            obj_we      = 1'b1;
            cmd.wsel    = vbt_pkg::WS_IN;
            wr_idx      = SW'(obj_cnt_r);
            obj_cnt_nxt = obj_cnt_r + 1'b1;
          end
          if (in_frame_end) begin
            sel_nxt   = 1'b0;
            i_nxt     = '0;
            hi_nxt    = SW'(obj_cnt_nxt);
            state_nxt = ST_SS_INIT;
          end
        end
      end

      // selection sort of [i, hi) by y, highest first
      ST_SS_INIT: begin
        if (({1'b0, i_r} + 1'b1) >= {1'b0, hi_r}) begin
          if (!sel_r) begin
            state_nxt = ST_M_INIT;
          end else begin
            first_nxt = hi_r;
            lvl_nxt   = lvl_r - 1'b1;
            state_nxt = ST_G_L;
          end
        end else begin
          rd_idx    = i_r;
          state_nxt = ST_SS_WS;
        end
      end
      ST_SS_WS: begin
        cmd.load_a = 1'b1;
        cmd.load_b = 1'b1;
        g_nxt      = i_r;
        j_nxt      = i_r + 1'b1;
        rd_idx     = i_r + 1'b1;
        state_nxt  = ST_SS_CMP;
      end
      ST_SS_CMP: begin
        if (sts.q_gt) begin
          cmd.load_b = 1'b1;
          g_nxt      = j_r;
        end
        if (({1'b0, j_r} + 1'b1) < {1'b0, hi_r}) begin
          j_nxt  = j_r + 1'b1;
          rd_idx = j_r + 1'b1;
        end else begin
          state_nxt = ST_SS_SWP;
        end
      end
      ST_SS_SWP: begin
        if (g_r != i_r) begin
          we        = 1'b1;
          wr_idx    = i_r;
          cmd.wsel  = vbt_pkg::WS_B;
          state_nxt = ST_SS_SWP2;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SS_INIT;
        end
      end
      ST_SS_SWP2: begin
        we        = 1'b1;
        wr_idx    = g_r;
        cmd.wsel  = vbt_pkg::WS_A;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_SS_INIT;
      end

      // match each object against the track store
      ST_M_INIT: begin
        sel_nxt       = 1'b1;
        cmd.clr_flags = 1'b1;
        k_nxt         = '0;
        n_nxt         = cnt_r;
        state_nxt     = ST_M_OBJ;
      end
      ST_M_OBJ: begin
        if (k_r == SW'(obj_cnt_r)) begin
          i_nxt     = '0;
          state_nxt = ST_D_RD;
        end else begin
          rd_idx    = k_r;
          state_nxt = ST_M_OBJW;
        end
      end
      ST_M_OBJW: begin
        cmd.load_o = 1'b1;
        i_nxt      = '0;
        if (n_r == '0) begin
          state_nxt = ST_M_NEW;
        end else begin
          rd_idx    = '0;
          state_nxt = ST_M_SCAN;
        end
      end
      ST_M_SCAN: begin
        if (sts.is_match) begin
          we           = 1'b1;
          wr_idx       = i_r;
          cmd.wsel     = vbt_pkg::WS_BLEND;
          cmd.set_flag = 1'b1;
          k_nxt        = k_r + 1'b1;
          state_nxt    = ST_M_OBJ;
        end else if (({1'b0, i_r} + 1'b1) < {1'b0, n_r}) begin
          i_nxt  = i_r + 1'b1;
          rd_idx = i_r + 1'b1;
        end else begin
          state_nxt = ST_M_NEW;
        end
      end
      ST_M_NEW: begin
        if (n_r < SW'(TRACK_SLOTS)) begin
          we           = 1'b1;
          wr_idx       = n_r;
          cmd.wsel     = vbt_pkg::WS_NEW;
          cmd.set_flag = 1'b1;
          n_nxt        = n_r + 1'b1;
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = ST_M_OBJ;
      end

      // unmatched tracks lose one life
      ST_D_RD: begin
        if (i_r == n_r) begin
          first_nxt = '0;
          lvl_nxt   = sts.max_life;
          state_nxt = ST_G_L;
        end else begin
          rd_idx    = i_r;
          state_nxt = ST_D_WR;
        end
      end
      ST_D_WR: begin
        we        = 1'b1;
        wr_idx    = i_r;
        cmd.wsel  = vbt_pkg::WS_DEC;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_D_RD;
      end

      // gather tracks of life lvl at [first, end), then sort that group
      ST_G_L: begin
        if (lvl_r == '0) begin
          cnt_nxt   = first_r;
          k_nxt     = '0;
          state_nxt = ST_X_RD;
        end else begin
          i_nxt     = first_r;
          end_nxt   = first_r;
          jp_nxt    = '0;
          state_nxt = ST_P_I;
        end
      end
      ST_P_I: begin
        if (i_r >= n_r) begin
          i_nxt     = first_r;
          hi_nxt    = end_r;
          state_nxt = ST_SS_INIT;
        end else begin
          rd_idx    = i_r;
          state_nxt = ST_P_IW;
        end
      end
      ST_P_IW: begin
        cmd.load_a = 1'b1;
        if (sts.q_life == lvl_r) begin
          end_nxt   = i_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_P_I;
        end else begin
          // slots between i and jp are already known to hold other lives
          j_nxt     = (jp_r > i_r) ? jp_r : i_r + 1'b1;
          state_nxt = ST_P_J;
        end
      end
      ST_P_J: begin
        if (j_r >= n_r) begin
          i_nxt     = first_r;
          hi_nxt    = end_r;
          state_nxt = ST_SS_INIT;
        end else begin
          rd_idx    = j_r;
          state_nxt = ST_P_JW;
        end
      end
      ST_P_JW: begin
        if (sts.q_life == lvl_r) begin
          we        = 1'b1;
          wr_idx    = i_r;
          cmd.wsel  = vbt_pkg::WS_Q;
          state_nxt = ST_P_SW2;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_P_J;
        end
      end
      ST_P_SW2: begin
        we        = 1'b1;
        wr_idx    = j_r;
        cmd.wsel  = vbt_pkg::WS_A;
        jp_nxt    = j_r + 1'b1;
        end_nxt   = i_r + 1'b1;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_P_I;
      end

      // export the leading slots
      ST_X_RD: begin
        rd_idx    = k_r;
        state_nxt = ST_X_EM;
      end
      ST_X_EM: begin
        cmd.emit       = 1'b1;
        cmd.emit_valid = (k_r < cnt_r);
        cmd.emit_last  = (k_r == SW'(MAX_OBJECTS - 1));
        if (k_r == SW'(MAX_OBJECTS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_X_RD;
        end
      end
      ST_DONE: begin
        obj_cnt_nxt = '0;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (we && !sel_r) begin
      obj_we = 1'b1;
    end
  end

  assign trk_we    = we && sel_r;
  assign obj_waddr = wr_idx[OAW-1:0];
  assign obj_raddr = rd_idx[OAW-1:0];
  assign trk_waddr = wr_idx[AW-1:0];
  assign trk_raddr = rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      obj_cnt_r <= '0;
      cnt_r     <= '0;
      sel_r     <= 1'b1;
      i_r       <= '0;
      j_r       <= '0;
      g_r       <= '0;
      hi_r      <= '0;
      jp_r      <= '0;
      first_r   <= '0;
      end_r     <= '0;
      n_r       <= '0;
      k_r       <= '0;
      lvl_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      obj_cnt_r <= obj_cnt_nxt;
      cnt_r     <= cnt_nxt;
      sel_r     <= sel_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      g_r       <= g_nxt;
      hi_r      <= hi_nxt;
      jp_r      <= jp_nxt;
      first_r   <= first_nxt;
      end_r     <= end_nxt;
      n_r       <= n_nxt;
      k_r       <= k_nxt;
      lvl_r     <= lvl_nxt;
    end
  end

endmodule

>>> src/vision_blob_tracker_unit.sv
// items: an item without frame end leaves busy low.
// a frame end starts the object sort, track match, life update, grouping with
// per-group sort and export, all through one read port of the track store.
// results: MAX_OBJECTS strobes at the end of that run.
// reset: synchronous active-low rst_n clears the entry counts, restores config.
// ----------------------------------------------------------------------------
// vision_blob_tracker_unit
// Frame-to-frame blob tracker: buffers objects, matches them to tracks,
// ages and orders the tracks, and exports the leading slots each frame.
// ----------------------------------------------------------------------------
module vision_blob_tracker_unit #(
  parameter int MAX_OBJECTS = 8,
  parameter int TRACK_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_object_present,
  input  logic [vbt_pkg::SigW-1:0]     in_signature,
  input  logic [vbt_pkg::CoordW-1:0]   in_pos_x,
  input  logic [vbt_pkg::CoordW-1:0]   in_pos_y,
  input  logic [vbt_pkg::CoordW-1:0]   in_blob_width,
  input  logic [vbt_pkg::CoordW-1:0]   in_blob_height,
  input  logic [vbt_pkg::CoordW-1:0]   in_centre_x,
  input  logic [vbt_pkg::CoordW-1:0]   in_centre_y,
  input  logic                         in_frame_end,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vbt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vbt_pkg::CfgDataW-1:0] cfg_data,
  output logic                         out_valid,
  output logic                         out_track_valid,
  output logic [vbt_pkg::SigW-1:0]     out_signature,
  output logic [vbt_pkg::CoordW-1:0]   out_x,
  output logic [vbt_pkg::CoordW-1:0]   out_y,
  output logic [vbt_pkg::CoordW-1:0]   out_width,
  output logic [vbt_pkg::CoordW-1:0]   out_height,
  output logic [vbt_pkg::CoordW-1:0]   out_size,
  output logic [vbt_pkg::CoordW-1:0]   out_centre_x,
  output logic [vbt_pkg::CoordW-1:0]   out_centre_y,
  output logic                         out_last_slot
);

  localparam int OAW = MAX_OBJECTS > 1 ? $clog2(MAX_OBJECTS) : 1;
  localparam int AW  = $clog2(TRACK_SLOTS);

  vbt_pkg::cmd_t  cmd;
  vbt_pkg::sts_t  sts;
  logic           obj_we, trk_we;
  logic [OAW-1:0] obj_waddr, obj_raddr;
  logic [AW-1:0]  trk_waddr, trk_raddr;

  vbt_ctrl #(.MAX_OBJECTS(MAX_OBJECTS), .TRACK_SLOTS(TRACK_SLOTS)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_object_present(in_object_present),
    .in_signature     (in_signature),
    .in_frame_end     (in_frame_end),
    .sts              (sts),
    .cmd              (cmd),
    .obj_we           (obj_we),
    .obj_waddr        (obj_waddr),
    .obj_raddr        (obj_raddr),
    .trk_we           (trk_we),
    .trk_waddr        (trk_waddr),
    .trk_raddr        (trk_raddr)
  );

  vbt_dp #(.MAX_OBJECTS(MAX_OBJECTS), .TRACK_SLOTS(TRACK_SLOTS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .obj_we         (obj_we),
    .obj_waddr      (obj_waddr),
    .obj_raddr      (obj_raddr),
    .trk_we         (trk_we),
    .trk_waddr      (trk_waddr),
    .trk_raddr      (trk_raddr),
    .sts            (sts),
    .in_signature   (in_signature),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_blob_width  (in_blob_width),
    .in_blob_height (in_blob_height),
    .in_centre_x    (in_centre_x),
    .in_centre_y    (in_centre_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_track_valid(out_track_valid),
    .out_signature  (out_signature),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_size       (out_size),
    .out_centre_x   (out_centre_x),
    .out_centre_y   (out_centre_y),
    .out_last_slot  (out_last_slot)
  );

endmodule

>>> src/vbt_checker.sv
// ----------------------------------------------------------------------------
// vbt_checker
// Port-level checks of the blob tracker, bound to the top level.
// ----------------------------------------------------------------------------
module vbt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_frame_end,
  input logic                       out_valid,
  input logic                       out_track_valid,
  input logic [vbt_pkg::SigW-1:0]   out_signature,
  input logic [vbt_pkg::CoordW-1:0] out_x,
  input logic [vbt_pkg::CoordW-1:0] out_size,
  input logic                       out_last_slot
);

  // an item that does not close a frame leaves the block idle
  a_plain_item: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_frame_end |=> !busy)
    else $error("block went busy on a mid-frame transfer");

  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_frame_end |=> busy)
    else $error("frame end did not start processing");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_slot |=> !out_valid)
    else $error("result after the last slot of a frame");

  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_track_valid |-> out_signature == '0 && out_x == '0 &&
                                      out_size == '0)
    else $error("invalid slot carries data");

  a_reset: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("reset did not idle the block");

endmodule

bind vision_blob_tracker_unit vbt_checker u_vbt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_frame_end   (in_frame_end),
  .out_valid      (out_valid),
  .out_track_valid(out_track_valid),
  .out_signature  (out_signature),
  .out_x          (out_x),
  .out_size       (out_size),
  .out_last_slot  (out_last_slot)
);
